[hw/rtl/pmjs_pkg.sv]
// Shared types, constants and command codes of the job scheduler.
package pmjs_pkg;

    localparam int JOB_SLOTS = 8;
    localparam int SLOT_W    = $clog2(JOB_SLOTS);
    localparam int CNT_W     = $clog2(JOB_SLOTS + 1);
    localparam int FIRED_W   = 8;
    localparam int ACTIVE_W  = 4;
    localparam int PERIOD_W  = 23;
    localparam int MINUTES_W = 60;
    localparam int STAMP_W   = 27;
    localparam int ADDR_W    = 3;
    localparam int MS_PER_SEC = 1000;

    // Reciprocal of 60 scaled by 2^37; exact for every 32-bit dividend.
    localparam logic [31:0] DIV60_MAGIC = 32'h8888_8889;
    localparam int DIV60_SHIFT = 37;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_SYNC  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NONE  = 2'd3
    } pmjs_cmd_t;

    typedef enum logic [0:0] {
        REG_ACTIVE_JOBS = 1'b0
    } pmjs_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_A,
        ST_DIV_B,
        ST_DIV_C,
        ST_DIV_D,
        ST_SCAN,
        ST_SYNC,
        ST_WRITE,
        ST_DONE
    } pmjs_state_t;

    typedef struct packed {
        logic [1:0]           command;
        logic [31:0]          epoch_seconds;
        logic [31:0]          now_ms;
        logic                 sync_flag;
        logic [2:0]           job_index;
        logic                 job_periodic;
        logic [PERIOD_W-1:0]  job_period;
        logic [MINUTES_W-1:0] job_minute_mask;
    } pmjs_req_t;

    typedef struct packed {
        logic [FIRED_W-1:0] fired_mask;
        logic               time_synced;
    } pmjs_rsp_t;

    typedef struct packed {
        logic load_in;
        logic mul_epoch;
        logic take_stamp;
        logic mul_stamp;
        logic take_minute;
        logic tick_step;
        logic sync_step;
        logic write_job;
        logic load_out;
    } pmjs_ctrl_t;

    typedef struct packed {
        logic slots_done;
        logic out_free;
    } pmjs_stat_t;

endpackage

[hw/rtl/periodic_and_minute_job_scheduler_core.sv]
// Top level of the job scheduler: configuration register, controller and datapath.
//
// Each request transfer yields exactly one response transfer. A request is taken only
// while the controller is idle, so requests are handled one at a time; a finished
// response waits in its own output register and the next request is taken meanwhile.
// A tick splits the epoch into minute and second on one shared reciprocal multiplier
// (ST_DIV_A to ST_DIV_D), then scans min(active_jobs, 8) table slots one per cycle; a
// set-sync walks the same slots one per cycle, rewinding each if sync_flag is set.
// The slot scan through the single-ported job table sets the rate. active_jobs sits
// at byte address 0 of the register port; the user is to change it only while the
// block is idle, and the block itself does not enforce this.
module periodic_and_minute_job_scheduler_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_ready,
    input  pmjs_pkg::pmjs_req_t             req,
    output logic                            rsp_valid,
    input  logic                            rsp_ready,
    output pmjs_pkg::pmjs_rsp_t             rsp,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pmjs_pkg::ADDR_W-1:0]     paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [pmjs_pkg::ACTIVE_W-1:0] active_jobs_reg;
    logic                          reg_sel;
    pmjs_pkg::pmjs_ctrl_t          ctrl;
    pmjs_pkg::pmjs_stat_t          stat;

    assign reg_sel = (pmjs_pkg::pmjs_reg_t'(paddr[2]) == pmjs_pkg::REG_ACTIVE_JOBS);
    assign pready  = 1'b1;
    assign prdata  = reg_sel ? 32'(active_jobs_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_jobs_reg <= '0;
        end
        else if (psel && penable && pwrite && reg_sel)
        begin
            active_jobs_reg <= pwdata[pmjs_pkg::ACTIVE_W-1:0];
        end
    end

    pmjs_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .command   (req.command),
        .stat      (stat),
        .req_ready (req_ready),
        .ctrl      (ctrl)
    );

    pmjs_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp_ready   (rsp_ready),
        .active_jobs (active_jobs_reg),
        .ctrl        (ctrl),
        .stat        (stat),
        .rsp_valid   (rsp_valid),
        .rsp         (rsp)
    );

endmodule

[hw/rtl/pmjs_ctrl.sv]
// Controller state machine that sequences each transfer through the datapath.
module pmjs_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    input  logic [1:0]           command,
    input  pmjs_pkg::pmjs_stat_t stat,
    output logic                 req_ready,
    output pmjs_pkg::pmjs_ctrl_t ctrl
);

    pmjs_pkg::pmjs_state_t state_reg;
    pmjs_pkg::pmjs_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pmjs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pmjs_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (pmjs_pkg::pmjs_cmd_t'(command))
                        pmjs_pkg::CMD_TICK:  state_next = pmjs_pkg::ST_DIV_A;
                        pmjs_pkg::CMD_SYNC:  state_next = pmjs_pkg::ST_SYNC;
                        pmjs_pkg::CMD_WRITE: state_next = pmjs_pkg::ST_WRITE;
                        default:             state_next = pmjs_pkg::ST_DONE;
                    endcase
                end
            end
            pmjs_pkg::ST_DIV_A: state_next = pmjs_pkg::ST_DIV_B;
            pmjs_pkg::ST_DIV_B: state_next = pmjs_pkg::ST_DIV_C;
            pmjs_pkg::ST_DIV_C: state_next = pmjs_pkg::ST_DIV_D;
            pmjs_pkg::ST_DIV_D: state_next = pmjs_pkg::ST_SCAN;
            pmjs_pkg::ST_SCAN,
            pmjs_pkg::ST_SYNC:
            begin
                if (stat.slots_done)
                begin
                    state_next = pmjs_pkg::ST_DONE;
                end
            end
            pmjs_pkg::ST_WRITE: state_next = pmjs_pkg::ST_DONE;
            pmjs_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = pmjs_pkg::ST_IDLE;
                end
            end
            default: state_next = pmjs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl      = '0;
        req_ready = 1'b0;
        case (state_reg)
            pmjs_pkg::ST_IDLE:
            begin
                req_ready    = 1'b1;
                ctrl.load_in = req_valid;
            end
            pmjs_pkg::ST_DIV_A: ctrl.mul_epoch   = 1'b1;
            pmjs_pkg::ST_DIV_B: ctrl.take_stamp  = 1'b1;
            pmjs_pkg::ST_DIV_C: ctrl.mul_stamp   = 1'b1;
            pmjs_pkg::ST_DIV_D: ctrl.take_minute = 1'b1;
            pmjs_pkg::ST_SCAN:  ctrl.tick_step   = !stat.slots_done;
            pmjs_pkg::ST_SYNC:  ctrl.sync_step   = !stat.slots_done;
            pmjs_pkg::ST_WRITE: ctrl.write_job   = 1'b1;
            pmjs_pkg::ST_DONE:  ctrl.load_out    = stat.out_free;
            default:
            begin
                ctrl      = '0;
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

[hw/rtl/pmjs_datapath.sv]
// Datapath: job table, time split into minute and second, slot scan and result register.
module pmjs_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  pmjs_pkg::pmjs_req_t                 req,
    input  logic                                rsp_ready,
    input  logic [pmjs_pkg::ACTIVE_W-1:0]       active_jobs,
    input  pmjs_pkg::pmjs_ctrl_t                ctrl,
    output pmjs_pkg::pmjs_stat_t                stat,
    output logic                                rsp_valid,
    output pmjs_pkg::pmjs_rsp_t                 rsp
);

    // Job table.
    logic [pmjs_pkg::JOB_SLOTS-1:0]   kind_reg;
    logic [pmjs_pkg::PERIOD_W-1:0]    interval_reg [pmjs_pkg::JOB_SLOTS];
    logic [31:0]                      interval_ms_reg [pmjs_pkg::JOB_SLOTS];
    logic [pmjs_pkg::MINUTES_W-1:0]   minutes_reg [pmjs_pkg::JOB_SLOTS];
    logic [31:0]                      last_run_reg [pmjs_pkg::JOB_SLOTS];

    logic                             synced_reg;
    logic [pmjs_pkg::CNT_W-1:0]       slot_reg;
    logic [pmjs_pkg::FIRED_W-1:0]     fired_reg;
    logic                             rsp_valid_reg;

    pmjs_pkg::pmjs_req_t              item_reg;
    logic [63:0]                      prod_reg;
    logic [pmjs_pkg::STAMP_W-1:0]     stamp_reg;
    logic [5:0]                       sec_reg;
    logic [5:0]                       minute_reg;
    pmjs_pkg::pmjs_rsp_t              rsp_reg;

    logic [pmjs_pkg::CNT_W-1:0]       active_count;
    logic [pmjs_pkg::SLOT_W-1:0]      slot_idx;
    logic [pmjs_pkg::SLOT_W-1:0]      wr_idx;
    logic                             sel_kind;
    logic [31:0]                      sel_last;
    logic [63:0]                      sel_mask;
    logic [31:0]                      epoch_diff;
    logic [31:0]                      ms_diff;
    logic                             hit;
    logic [31:0]                      new_last;
    logic [31:0]                      mul_a;
    logic [pmjs_pkg::STAMP_W-1:0]     quot;
    logic [31:0]                      stamp_x60;
    logic [31:0]                      quot_x60;
    logic [32:0]                      ms_wide;
    logic [31:0]                      ms_interval;

    always_comb
    begin
        if (32'(active_jobs) > pmjs_pkg::JOB_SLOTS)
        begin
            active_count = pmjs_pkg::CNT_W'(pmjs_pkg::JOB_SLOTS);
        end
        else
        begin
            active_count = pmjs_pkg::CNT_W'(active_jobs);
        end
    end

    assign slot_idx = slot_reg[pmjs_pkg::SLOT_W-1:0];
    assign wr_idx   = pmjs_pkg::SLOT_W'(item_reg.job_index);

    // Shared reciprocal multiplier: first for epoch / 60, then for minute-count / 60.
    assign mul_a     = ctrl.mul_stamp ? 32'(stamp_reg) : item_reg.epoch_seconds;
    assign quot      = prod_reg[63:pmjs_pkg::DIV60_SHIFT];
    assign stamp_x60 = 32'({stamp_reg, 6'b0}) - 32'({stamp_reg, 2'b0});
    assign quot_x60  = 32'({quot, 6'b0}) - 32'({quot, 2'b0});

    // Period in milliseconds, saturated to 32 bits, kept beside the period itself.
    assign ms_wide     = 33'(item_reg.job_period) * 33'(pmjs_pkg::MS_PER_SEC);
    assign ms_interval = ms_wide[32] ? '1 : ms_wide[31:0];

    assign sel_kind   = kind_reg[slot_idx];
    assign sel_last   = last_run_reg[slot_idx];
    assign sel_mask   = 64'(minutes_reg[slot_idx]);
    assign epoch_diff = item_reg.epoch_seconds - sel_last;
    assign ms_diff    = item_reg.now_ms - sel_last;

    always_comb
    begin
        hit      = 1'b0;
        new_last = sel_last;
        if (synced_reg)
        begin
            if (sel_kind)
            begin
                hit      = epoch_diff >= 32'(interval_reg[slot_idx]);
                new_last = item_reg.epoch_seconds;
            end
            else
            begin
                hit      = (sel_last != 32'(stamp_reg)) && (sec_reg == 6'd0)
                           && sel_mask[minute_reg];
                new_last = 32'(stamp_reg);
            end
        end
        else if (sel_kind)
        begin
            hit      = ms_diff >= interval_ms_reg[slot_idx];
            new_last = item_reg.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= '0;
            synced_reg    <= 1'b0;
            slot_reg      <= '0;
            fired_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < pmjs_pkg::JOB_SLOTS; i++)
            begin
                interval_reg[i]    <= '0;
                interval_ms_reg[i] <= '0;
                minutes_reg[i]     <= '0;
                last_run_reg[i]    <= '0;
            end
        end
        else
        begin
            if (ctrl.load_in)
            begin
                slot_reg  <= '0;
                fired_reg <= '0;
            end
            if (ctrl.tick_step)
            begin
                slot_reg <= slot_reg + 1'b1;
                if (hit)
                begin
                    fired_reg[slot_idx]    <= 1'b1;
                    last_run_reg[slot_idx] <= new_last;
                end
            end
            if (ctrl.sync_step)
            begin
                slot_reg   <= slot_reg + 1'b1;
                synced_reg <= item_reg.sync_flag;
                if (item_reg.sync_flag)
                begin
                    last_run_reg[slot_idx] <= sel_kind ?
                        (item_reg.epoch_seconds - 32'd1) : 32'd0;
                end
            end
            // With no active slots the rewind loop does not run, so the mode is set here too.
            if (ctrl.load_out && (pmjs_pkg::pmjs_cmd_t'(item_reg.command) == pmjs_pkg::CMD_SYNC))
            begin
                synced_reg <= item_reg.sync_flag;
            end
            if (ctrl.write_job && (32'(item_reg.job_index) < pmjs_pkg::JOB_SLOTS))
            begin
                kind_reg[wr_idx]        <= item_reg.job_periodic;
                interval_reg[wr_idx]    <= item_reg.job_period;
                interval_ms_reg[wr_idx] <= ms_interval;
                minutes_reg[wr_idx]     <= item_reg.job_minute_mask;
                last_run_reg[wr_idx]    <= '0;
            end
            if (ctrl.load_out)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_in)
        begin
            item_reg <= req;
        end
        if (ctrl.mul_epoch || ctrl.mul_stamp)
        begin
            prod_reg <= {32'b0, mul_a} * {32'b0, pmjs_pkg::DIV60_MAGIC};
        end
        if (ctrl.take_stamp)
        begin
            stamp_reg <= quot;
        end
        if (ctrl.mul_stamp)
        begin
            sec_reg <= 6'(item_reg.epoch_seconds - stamp_x60);
        end
        if (ctrl.take_minute)
        begin
            minute_reg <= 6'(32'(stamp_reg) - quot_x60);
        end
        if (ctrl.load_out)
        begin
            rsp_reg.fired_mask  <= fired_reg;
            rsp_reg.time_synced <=
                (pmjs_pkg::pmjs_cmd_t'(item_reg.command) == pmjs_pkg::CMD_SYNC) ?
                item_reg.sync_flag : synced_reg;
        end
    end

    assign stat.slots_done = (slot_reg >= active_count);
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;
    assign rsp_valid       = rsp_valid_reg;
    assign rsp             = rsp_reg;

endmodule

[sim/tb_periodic_and_minute_job_scheduler_core.sv]
// Self-checking testbench for the periodic and minute job scheduler core.
`timescale 1ns / 1ps

module tb_periodic_and_minute_job_scheduler_core;
    import pmjs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    pmjs_req_t   req = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    pmjs_rsp_t   rsp;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    periodic_and_minute_job_scheduler_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #10 clk = ~clk;

    // Scheduler state as the testbench expects it to be.
    logic                 sync_mode = 1'b0;
    logic [ACTIVE_W-1:0]  active_cfg = '0;
    logic                 slot_periodic [JOB_SLOTS] = '{default: 1'b0};
    logic [PERIOD_W-1:0]  slot_period [JOB_SLOTS] = '{default: '0};
    logic [MINUTES_W-1:0] slot_minutes [JOB_SLOTS] = '{default: '0};
    logic [31:0]          slot_last_run [JOB_SLOTS] = '{default: '0};

    pmjs_req_t   pending_reqs [$];
    pmjs_rsp_t   awaited_fire_rsps [$];

    int unsigned reqs_queued = 0;
    int unsigned reqs_taken = 0;
    int unsigned ticks_taken = 0;
    int unsigned firing_rsps = 0;
    int unsigned settings_written = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;

    logic        req_took = 1'b0;
    logic        rsp_took = 1'b0;
    int unsigned send_gap = 0;
    int unsigned send_calm = 0;
    int unsigned rsp_stall = 0;
    int unsigned rsp_calm = 0;

    logic [31:0] gen_epoch = '0;
    logic [31:0] gen_ms = '0;

    function automatic pmjs_rsp_t compute_fire_rsp(input pmjs_req_t r);
        pmjs_rsp_t   o;
        int unsigned n;
        int unsigned i;
        logic [31:0] sec_part;
        logic [31:0] stamp;
        logic [31:0] minute;
        logic [31:0] span;
        logic [31:0] ms_interval;
        logic [63:0] wide;
        logic        hit;
        o = '0;
        n = (active_cfg > JOB_SLOTS) ? JOB_SLOTS : active_cfg;
        case (pmjs_cmd_t'(r.command))
            CMD_TICK:
            begin
                sec_part = r.epoch_seconds % 60;
                stamp    = r.epoch_seconds / 60;
                minute   = stamp % 60;
                for (i = 0; i < n; i++)
                begin
                    hit = 1'b0;
                    if (sync_mode)
                    begin
                        if (slot_periodic[i])
                        begin
                            span = r.epoch_seconds - slot_last_run[i];
                            if (span >= {9'd0, slot_period[i]})
                            begin
                                hit = 1'b1;
                                slot_last_run[i] = r.epoch_seconds;
                            end
                        end
                        else if (slot_last_run[i] != stamp && sec_part == 0 &&
                                 slot_minutes[i][minute[5:0]])
                        begin
                            hit = 1'b1;
                            slot_last_run[i] = stamp;
                        end
                    end
                    else if (slot_periodic[i])
                    begin
                        // The millisecond interval saturates when it no longer fits 32 bits.
                        wide = 64'(slot_period[i]) * 64'(MS_PER_SEC);
                        ms_interval = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
                        span = r.now_ms - slot_last_run[i];
                        if (span >= ms_interval)
                        begin
                            hit = 1'b1;
                            slot_last_run[i] = r.now_ms;
                        end
                    end
                    if (hit && i < FIRED_W)
                        o.fired_mask[i] = 1'b1;
                end
            end
            CMD_SYNC:
            begin
                sync_mode = r.sync_flag;
                if (r.sync_flag)
                begin
                    for (i = 0; i < n; i++)
                        slot_last_run[i] = slot_periodic[i] ? r.epoch_seconds - 32'd1 : 32'd0;
                end
            end
            CMD_WRITE:
            begin
                if (r.job_index < JOB_SLOTS)
                begin
                    slot_periodic[r.job_index] = r.job_periodic;
                    slot_period[r.job_index]   = r.job_period;
                    slot_minutes[r.job_index]  = r.job_minute_mask;
                    slot_last_run[r.job_index] = '0;
                end
            end
            default:
            begin
            end
        endcase
        o.time_synced = sync_mode;
        return o;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // A calm stretch forces back-to-back transfers for a while.
    task automatic next_gap(inout int unsigned calm, output int unsigned gap);
        if (calm != 0)
        begin
            calm--;
            gap = 0;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(63) == 0)
                calm = $urandom_range(20, 80);
        end
    endtask

    function automatic pmjs_req_t noise_item();
        pmjs_req_t r;
        r.command         = 2'($urandom);
        r.epoch_seconds   = $urandom;
        r.now_ms          = $urandom;
        r.sync_flag       = 1'($urandom);
        r.job_index       = 3'($urandom);
        r.job_periodic    = 1'($urandom);
        r.job_period      = PERIOD_W'($urandom);
        r.job_minute_mask = {28'($urandom), 32'($urandom)};
        return r;
    endfunction

    task automatic queue_req(input pmjs_req_t r);
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    task automatic queue_tick(input logic [31:0] epoch, input logic [31:0] ms);
        pmjs_req_t r;
        r = noise_item();
        r.command       = CMD_TICK;
        r.epoch_seconds = epoch;
        r.now_ms        = ms;
        queue_req(r);
    endtask

    task automatic queue_sync(input logic flag, input logic [31:0] epoch);
        pmjs_req_t r;
        r = noise_item();
        r.command       = CMD_SYNC;
        r.sync_flag     = flag;
        r.epoch_seconds = epoch;
        queue_req(r);
    endtask

    task automatic queue_job(input logic [2:0] idx, input logic periodic,
                             input logic [PERIOD_W-1:0] period,
                             input logic [MINUTES_W-1:0] minutes);
        pmjs_req_t r;
        r = noise_item();
        r.command         = CMD_WRITE;
        r.job_index       = idx;
        r.job_periodic    = periodic;
        r.job_period      = period;
        r.job_minute_mask = minutes;
        queue_req(r);
    endtask

    task automatic queue_unused();
        pmjs_req_t r;
        r = noise_item();
        r.command = CMD_NONE;
        queue_req(r);
    endtask

    // Mostly a running clock with small steps and minute boundaries, so that jobs fire.
    task automatic queue_random_item();
        int unsigned roll;
        int unsigned step;
        logic [PERIOD_W-1:0]  period;
        logic [MINUTES_W-1:0] minutes;
        roll = $urandom_range(99);
        if (roll < 65)
        begin
            step = $urandom_range(99);
            if (step < 30)
                gen_epoch = gen_epoch + 1;
            else if (step < 45)
                gen_epoch = gen_epoch;
            else if (step < 70)
                gen_epoch = gen_epoch - (gen_epoch % 60) + 60;
            else if (step < 85)
                gen_epoch = gen_epoch + $urandom_range(2, 50);
            else if (step < 95)
                gen_epoch = gen_epoch - (gen_epoch % 60) + 60 * $urandom_range(1, 90);
            else
                gen_epoch = $urandom;
            gen_ms = ($urandom_range(19) == 0) ? 32'($urandom) : gen_ms + $urandom_range(0, 3000);
            queue_tick(gen_epoch, gen_ms);
        end
        else if (roll < 82)
        begin
            step = $urandom_range(99);
            if (step < 60)
                period = PERIOD_W'($urandom_range(0, 10));
            else if (step < 80)
                period = PERIOD_W'($urandom_range(11, 600));
            else if (step < 93)
                period = PERIOD_W'($urandom_range(0, 4294967));
            else
                period = PERIOD_W'($urandom_range(0, (1 << PERIOD_W) - 1));
            step = $urandom_range(99);
            if (step < 40)
                minutes = {28'($urandom), 32'($urandom)};
            else if (step < 70)
                minutes = MINUTES_W'(1) << $urandom_range(0, 59);
            else if (step < 85)
                minutes = '1;
            else
                minutes = '0;
            queue_job(3'($urandom), 1'($urandom), period, minutes);
        end
        else if (roll < 94)
            queue_sync($urandom_range(9) < 7, gen_epoch);
        else
            queue_unused();
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (reqs_taken != reqs_queued || awaited_fire_rsps.size() != 0);
        repeat (10) @(negedge clk);
    endtask

    // Writes active_jobs, then reads it back over the register port.
    task automatic set_active_jobs(input logic [ACTIVE_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ACTIVE_JOBS, 2'b00};
        pwdata  <= {28'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        active_cfg = value;
        settings_written++;
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== {28'd0, value})
        begin
            mismatches++;
            $display("%0t: active_jobs readback mismatch, expected %08h, got %08h",
                     $time, {28'd0, value}, prdata);
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin : req_accept
        if (rst_n && req_valid && req_ready)
        begin
            awaited_fire_rsps.push_back(compute_fire_rsp(req));
            reqs_taken++;
            if (pmjs_cmd_t'(req.command) == CMD_TICK)
                ticks_taken++;
            req_took = 1'b1;
        end
    end

    always @(negedge clk)
    begin : req_drive
        logic next_valid;
        next_valid = req_valid;
        if (rst_n && (!req_valid || req_took))
        begin
            req_took = 1'b0;
            if (send_gap != 0)
            begin
                send_gap--;
                next_valid = 1'b0;
            end
            else if (pending_reqs.size() != 0)
            begin
                req <= pending_reqs.pop_front();
                next_valid = 1'b1;
                next_gap(send_calm, send_gap);
            end
            else
                next_valid = 1'b0;
        end
        req_valid <= next_valid;
    end

    always @(posedge clk)
    begin : rsp_check
        pmjs_rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            rsp_took = 1'b1;
            if (rsp.fired_mask != '0)
                firing_rsps++;
            if (awaited_fire_rsps.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected transfer, expected none, got fired_mask %02h synced %0b",
                         $time, rsp.fired_mask, rsp.time_synced);
            end
            else
            begin
                want = awaited_fire_rsps.pop_front();
                if (rsp.fired_mask !== want.fired_mask)
                begin
                    mismatches++;
                    $display("%0t: fired_mask mismatch, expected %02h, got %02h",
                             $time, want.fired_mask, rsp.fired_mask);
                end
                if (rsp.time_synced !== want.time_synced)
                begin
                    mismatches++;
                    $display("%0t: time_synced mismatch, expected %0b, got %0b",
                             $time, want.time_synced, rsp.time_synced);
                end
            end
        end
    end

    always @(negedge clk)
    begin : rsp_drive
        if (rsp_took)
        begin
            rsp_took = 1'b0;
            next_gap(rsp_calm, rsp_stall);
        end
        else if (rsp_stall == 0 && rsp_calm == 0 && $urandom_range(15) == 0)
            rsp_stall = pick_gap();
        if (rsp_stall != 0)
        begin
            rsp_stall--;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d transfers outstanding",
                     cycle_count, awaited_fire_rsps.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [ACTIVE_W-1:0] settings [7];
        int unsigned         counts [7];
        int unsigned         p;
        int unsigned         k;
        settings = '{4'd3, 4'd15, 4'd0, 4'd8, 4'd1, 4'd9, 4'd5};
        counts   = '{150, 150, 90, 170, 150, 150, 170};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_active_jobs(4'd8);
        queue_unused();
        queue_job(3'd0, 1'b1, 23'd0, '0);
        queue_job(3'd1, 1'b1, '1, '0);
        queue_job(3'd2, 1'b1, 23'd4294967, '0);
        queue_job(3'd3, 1'b0, 23'd5, '1);
        queue_job(3'd4, 1'b0, 23'd5, '0);
        queue_job(3'd5, 1'b0, 23'd5, 60'h800_0000_0000_0000);
        queue_job(3'd6, 1'b1, 23'd1, '0);
        queue_job(3'd7, 1'b0, 23'd5, 60'd1);
        // Unsynchronized ticks, including the wrap of the millisecond count.
        queue_tick(32'd0, 32'd0);
        queue_tick(32'd0, 32'hFFFF_FFFF);
        queue_tick(32'd0, 32'd1000);
        queue_sync(1'b1, 32'd0);
        // Minute matching at second zero, a repeated minute, and minute 59.
        queue_tick(32'd0, 32'd0);
        queue_tick(32'd60, 32'd0);
        queue_tick(32'd3540, 32'd0);
        queue_tick(32'd3540, 32'd0);
        queue_tick(32'd3541, 32'd0);
        queue_tick(32'd3600, 32'd0);
        queue_tick(32'hFFFF_FFFF, 32'd0);
        // Synchronizing again while already synchronized rewinds the slots once more.
        queue_sync(1'b1, 32'd3600);
        queue_tick(32'd3600, 32'd0);
        queue_sync(1'b0, $urandom);
        queue_tick($urandom, $urandom);
        queue_job(3'd4, 1'b1, 23'd0, '1);
        queue_unused();
        wait_drained();

        for (p = 0; p < 7; p++)
        begin
            set_active_jobs(settings[p]);
            gen_epoch = $urandom;
            gen_ms    = $urandom;
            for (k = 0; k < counts[p]; k++)
            begin
                // The sender holds off halfway until every response is back.
                if (k == counts[p] / 2)
                    wait_drained();
                queue_random_item();
            end
            wait_drained();
        end

        repeat (40) @(negedge clk);
        $display("Covered %0d requests (%0d ticks, %0d responses with jobs firing)",
                 reqs_taken, ticks_taken, firing_rsps);
        $display("over %0d active_jobs settings from 0 to 15, in %0d cycles",
                 settings_written, cycle_count);
        if (mismatches == 0 && awaited_fire_rsps.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[periodic_and_minute_job_scheduler_core.f]
hw/rtl/pmjs_pkg.sv
hw/rtl/pmjs_ctrl.sv
hw/rtl/pmjs_datapath.sv
hw/rtl/periodic_and_minute_job_scheduler_core.sv
sim/tb_periodic_and_minute_job_scheduler_core.sv
